@@ design/assert_macros.svh @@
// Assertion macros for the RTL file that carries checks.
// Included by bare file name; no other dependencies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while in reset.
`define GSP_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, disabled while in reset.
`define GSP_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

@@ design/gsp_pkg.sv @@
// Shared types and constants for the dense graph shortest paths unit.
// No dependencies.
`default_nettype none

package gsp_pkg;

   localparam int MAX_VERTICES_DEFAULT = 16;
   localparam int VERTEX_W  = 4;
   localparam int WEIGHT_W  = 16;
   localparam int DIST_W    = 20;
   localparam int VCOUNT_W  = 5;
   localparam int CSR_ADDR_W = 3;
   localparam int CSR_DATA_W = 32;

   localparam logic [VCOUNT_W-1:0] VCOUNT_RESET = 5'd16;
   localparam logic [DIST_W-1:0]   DIST_MAX     = 20'hFFFFF;

   // register index within the CSR space (word address)
   localparam logic REG_VERTEX_COUNT = 1'b0;

   // item opcodes
   localparam logic OP_LOAD = 1'b0;
   localparam logic OP_RUN  = 1'b1;

   typedef enum logic [3:0] {
      ST_INIT,
      ST_IDLE,
      ST_CLEAR,
      ST_SCAN,
      ST_LOADV,
      ST_LOADD,
      ST_RELAX,
      ST_EMIT_RD,
      ST_EMIT_WR
   } state_type;

endpackage

`default_nettype wire

@@ design/gsp_ram.sv @@
// Simple dual-port synchronous RAM: one write port, one registered read port.
// Uses gsp_pkg only for the house import convention.
`default_nettype none

module gsp_ram
   import gsp_pkg::*;
#(
   parameter int ADDR_W = 4,
   parameter int DATA_W = 8
) (
   input  wire logic              clock,
   input  wire logic              we,
   input  wire logic [ADDR_W-1:0] waddr,
   input  wire logic [DATA_W-1:0] wdata,
   input  wire logic [ADDR_W-1:0] raddr,
   output logic      [DATA_W-1:0] rdata
);

   logic [DATA_W-1:0] mem_ff [(1 << ADDR_W)];

   // write port
   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
   end

   // read port, registered
   always_ff @(posedge clock) begin
      rdata <= mem_ff[raddr];
   end

endmodule

`default_nettype wire

@@ design/dense_graph_shortest_paths_unit.sv @@
// Single-source shortest paths over an adjacency matrix held in RAM.
// Channels: req_* takes items (opcode 0 writes one edge, opcode 1 runs from
// req_start_vertex); rsp_* delivers one result per vertex in use, ascending,
// with rsp_last on the final one. Handshake is valid/stall on both sides.
// The APB port holds vertex_count at address 0; write it only while idle.
// An edge load is written when taken (both vertices in range) and gives no result.
// A run with n vertices in use makes a clear pass over the distance RAM,
// then n rounds of a scan and, where a known vertex is found, a relax pass
// through the single read port of each RAM, then reads the results back
// out through the EMIT_RD and EMIT_WR states.
// The request side stalls for the whole run; the next item is taken as soon
// as the last result sits in the output register.
// After reset the edge RAM is cleared one entry a cycle, all 2^(2*clog2(
// MAX_VERTICES)) entries (256 for 16 vertices), while req_stall stays high.
// When the receiver stalls, the output register holds its result and the
// read-out sequence waits.
// Uses gsp_pkg, gsp_ram and assert_macros.svh.
`default_nettype none
`include "assert_macros.svh"

module dense_graph_shortest_paths_unit
   import gsp_pkg::*;
#(
   parameter int MAX_VERTICES = MAX_VERTICES_DEFAULT
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   // request channel
   input  wire logic                  req_valid,
   output logic                       req_stall,
   input  wire logic                  req_opcode,
   input  wire logic [VERTEX_W-1:0]   req_from_vertex,
   input  wire logic [VERTEX_W-1:0]   req_to_vertex,
   input  wire logic [WEIGHT_W-1:0]   req_edge_weight_in,
   input  wire logic                  req_edge_exists,
   input  wire logic [VERTEX_W-1:0]   req_start_vertex,
   // result channel
   output logic                       rsp_valid,
   input  wire logic                  rsp_stall,
   output logic      [VERTEX_W-1:0]   rsp_vertex,
   output logic      [DIST_W-1:0]     rsp_distance,
   output logic                       rsp_reachable,
   output logic      [VERTEX_W-1:0]   rsp_predecessor,
   output logic                       rsp_has_predecessor,
   output logic                       rsp_last,
   // configuration
   input  wire logic                  psel,
   input  wire logic                  penable,
   input  wire logic                  pwrite,
   input  wire logic [CSR_ADDR_W-1:0] paddr,
   input  wire logic [CSR_DATA_W-1:0] pwdata,
   output logic      [CSR_DATA_W-1:0] prdata,
   output logic                       pready
);

   localparam int VW  = $clog2(MAX_VERTICES);
   localparam int CW  = $clog2(MAX_VERTICES + 1);
   localparam int EAW = 2 * VW;
   localparam int EDW = 1 + WEIGHT_W;
   localparam int DDW = 2 + VW + DIST_W;

   state_type state_ff, state_in;

   logic [VCOUNT_W-1:0] vc_ff;
   logic [EAW-1:0]      init_ff;
   logic [CW-1:0]       cnt_ff, rnd_ff, n_w;
   logic [MAX_VERTICES-1:0] visited_ff;
   logic                found_ff, loc_ok_ff, start_ok_ff, pend_ff, pend_in;
   logic [DIST_W-1:0]   best_ff, dv_ff;
   logic [VW-1:0]       loc_ff, pend_idx_ff;
   logic [VERTEX_W-1:0] start_ff;
   logic                rsp_valid_ff;

   // memory ports
   logic            e_we;
   logic [EAW-1:0]  e_waddr, e_raddr;
   logic [EDW-1:0]  e_wdata, e_rdata;
   logic            d_we;
   logic [VW-1:0]   d_waddr, d_raddr;
   logic [DDW-1:0]  d_wdata, d_rdata;

   // decoded read data
   logic              rd_known, rd_pv, e_present, relax_hit, scan_hit;
   logic [VW-1:0]     rd_pred;
   logic [DIST_W-1:0] rd_dist, cand;
   logic [DIST_W:0]   sum;

   logic cfg_wr, req_acc, load_ok, cnt_lt_n, cnt_last, last_round, round_done, rsp_load;

   // vertices in use: zero reads as one, clamp at the maximum
   always_comb begin
      if (vc_ff == '0) begin
         n_w = CW'(1);
      end else if (32'(vc_ff) > MAX_VERTICES) begin
         n_w = CW'(MAX_VERTICES);
      end else begin
         n_w = CW'(vc_ff);
      end
   end

   assign cfg_wr     = psel & penable & pwrite & pready & (paddr[2] == REG_VERTEX_COUNT);
   assign pready     = 1'b1;
   assign prdata     = (paddr[2] == REG_VERTEX_COUNT) ?
                       CSR_DATA_W'(vc_ff) : '0;
   assign req_acc    = req_valid & ~req_stall;
   assign load_ok    = (32'(req_from_vertex) < MAX_VERTICES) &
                       (32'(req_to_vertex) < MAX_VERTICES);
   assign cnt_lt_n   = cnt_ff < n_w;
   assign cnt_last   = cnt_ff == CW'(n_w - 1'b1);
   assign last_round = rnd_ff == CW'(n_w - 1'b1);
   assign rsp_load   = (state_ff == ST_EMIT_WR) & (~rsp_valid_ff | ~rsp_stall);

   // read data fields
   assign rd_known  = d_rdata[DDW-1];
   assign rd_pv     = d_rdata[DDW-2];
   assign rd_pred   = d_rdata[DIST_W +: VW];
   assign rd_dist   = d_rdata[DIST_W-1:0];
   assign e_present = e_rdata[EDW-1];

   // candidate path length, saturating
   assign sum  = {1'b0, dv_ff} + (DIST_W + 1)'(e_rdata[WEIGHT_W-1:0]);
   assign cand = sum[DIST_W] ? DIST_MAX : sum[DIST_W-1:0];

   assign relax_hit = (state_ff == ST_RELAX) & pend_ff & e_present &
                      (~rd_known | (cand < rd_dist));
   assign scan_hit  = (state_ff == ST_SCAN) & pend_ff & ~visited_ff[pend_idx_ff] &
                      rd_known & (~found_ff | (rd_dist < best_ff));
   assign pend_in   = ((state_ff == ST_SCAN) | (state_ff == ST_RELAX)) & cnt_lt_n;

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_INIT:    if (init_ff == '1) state_in = ST_IDLE;
         ST_IDLE:    if (req_acc && req_opcode == OP_RUN) state_in = ST_CLEAR;
         ST_CLEAR:   if (cnt_last) state_in = ST_SCAN;
         ST_SCAN:    if (!cnt_lt_n) state_in = ST_LOADV;
         ST_LOADV: begin
            if (loc_ok_ff) state_in = ST_LOADD;
            else           state_in = last_round ? ST_EMIT_RD : ST_SCAN;
         end
         ST_LOADD: begin
            if (rd_known) state_in = ST_RELAX;
            else          state_in = last_round ? ST_EMIT_RD : ST_SCAN;
         end
         ST_RELAX:   if (!cnt_lt_n) state_in = last_round ? ST_EMIT_RD : ST_SCAN;
         ST_EMIT_RD: state_in = ST_EMIT_WR;
         ST_EMIT_WR: if (rsp_load) state_in = cnt_last ? ST_IDLE : ST_EMIT_RD;
         default:    state_in = ST_INIT;
      endcase
   end

   // outputs of the sequencer: handshake and memory controls
   always_comb begin
      req_stall = (state_ff != ST_IDLE);
      round_done = 1'b0;
      e_we    = 1'b0;
      e_waddr = {VW'(req_from_vertex), VW'(req_to_vertex)};
      e_wdata = {req_edge_exists, req_edge_weight_in};
      e_raddr = {loc_ff, cnt_ff[VW-1:0]};
      d_we    = 1'b0;
      d_waddr = cnt_ff[VW-1:0];
      d_wdata = {(32'(cnt_ff) == 32'(start_ff)), 1'b0, VW'(0), DIST_W'(0)};
      d_raddr = cnt_ff[VW-1:0];
      case (state_ff)
         ST_INIT: begin
            e_we    = 1'b1;
            e_waddr = init_ff;
            e_wdata = '0;
         end
         ST_IDLE:  e_we = req_acc & (req_opcode == OP_LOAD) & load_ok;
         ST_CLEAR: d_we = 1'b1;
         ST_LOADV: begin
            d_raddr    = loc_ff;
            round_done = ~loc_ok_ff;
         end
         ST_LOADD: round_done = ~rd_known;
         ST_RELAX: begin
            d_we       = relax_hit;
            d_waddr    = pend_idx_ff;
            d_wdata    = {1'b1, 1'b1, loc_ff, cand};
            round_done = ~cnt_lt_n;
         end
         default: ;
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_INIT;
         vc_ff        <= VCOUNT_RESET;
         init_ff      <= '0;
         pend_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         pend_ff  <= pend_in;
         if (cfg_wr) vc_ff <= pwdata[VCOUNT_W-1:0];
         if (state_ff == ST_INIT) init_ff <= init_ff + 1'b1;
         if (rsp_load) rsp_valid_ff <= 1'b1;
         else if (!rsp_stall) rsp_valid_ff <= 1'b0;
      end
   end

   // run datapath
   always_ff @(posedge clock) begin
      pend_idx_ff <= cnt_ff[VW-1:0];
      case (state_ff)
         ST_IDLE: begin
            cnt_ff      <= '0;
            start_ff    <= req_start_vertex;
            start_ok_ff <= 32'(req_start_vertex) < 32'(n_w);
            visited_ff  <= '0;
         end
         ST_CLEAR: begin
            if (cnt_last) begin
               cnt_ff    <= '0;
               rnd_ff    <= '0;
               found_ff  <= 1'b0;
               loc_ff    <= VW'(start_ff);
               loc_ok_ff <= start_ok_ff;
            end else begin
               cnt_ff <= cnt_ff + 1'b1;
            end
         end
         ST_SCAN: begin
            if (cnt_lt_n) cnt_ff <= cnt_ff + 1'b1;
            if (scan_hit) begin
               found_ff  <= 1'b1;
               best_ff   <= rd_dist;
               loc_ff    <= pend_idx_ff;
               loc_ok_ff <= 1'b1;
            end
         end
         ST_LOADV: if (loc_ok_ff) visited_ff[loc_ff] <= 1'b1;
         ST_LOADD: begin
            dv_ff <= rd_dist;
            if (rd_known) cnt_ff <= '0;
         end
         ST_RELAX: if (cnt_lt_n) cnt_ff <= cnt_ff + 1'b1;
         ST_EMIT_WR: begin
            if (rsp_load) begin
               cnt_ff              <= cnt_ff + 1'b1;
               rsp_vertex          <= VERTEX_W'(cnt_ff);
               rsp_reachable       <= rd_known;
               rsp_distance        <= rd_known ? rd_dist : '0;
               rsp_has_predecessor <= rd_known & rd_pv;
               rsp_predecessor     <= (rd_known & rd_pv) ? VERTEX_W'(rd_pred) : '0;
               rsp_last            <= cnt_last;
            end
         end
         default: ;
      endcase
      // end of a round: advance and rearm the scan
      if (round_done) begin
         rnd_ff    <= rnd_ff + 1'b1;
         cnt_ff    <= '0;
         found_ff  <= 1'b0;
         loc_ff    <= VW'(start_ff);
         loc_ok_ff <= start_ok_ff;
      end
   end

   assign rsp_valid = rsp_valid_ff;

   // adjacency matrix: {present, weight}
   gsp_ram #(.ADDR_W(EAW), .DATA_W(EDW)) u_edge_ram (
      .clock (clock),
      .we    (e_we),
      .waddr (e_waddr),
      .wdata (e_wdata),
      .raddr (e_raddr),
      .rdata (e_rdata)
   );

   // per-vertex state: {known, pred valid, pred, distance}
   gsp_ram #(.ADDR_W(VW), .DATA_W(DDW)) u_dist_ram (
      .clock (clock),
      .we    (d_we),
      .waddr (d_waddr),
      .wdata (d_wdata),
      .raddr (d_raddr),
      .rdata (d_rdata)
   );

   // checks
   `GSP_ASSERT_NOW(a_no_rw_overlap, clock, reset, d_we && (state_ff == ST_RELAX), d_waddr != d_raddr, "relax write collides with read")
   `GSP_ASSERT_NEXT(a_last_drains, clock, reset, rsp_valid && rsp_last && !rsp_stall && (state_ff != ST_EMIT_WR), !rsp_valid, "result after last of a run")
   `GSP_ASSERT_NOW(a_visited_bound, clock, reset, state_ff == ST_SCAN, $countones(visited_ff) <= 32'(rnd_ff), "more vertices visited than rounds")
   `GSP_ASSERT_NOW(a_busy_no_cfg_effect, clock, reset, rsp_valid && (state_ff == ST_INIT), 1'b0, "result during RAM clear")

endmodule

`default_nettype wire
